@@ rtl/upe_pkg.sv @@
`timescale 1ns / 1ps
// upe_pkg: shared types, constants and the hex digit function for the
// percent encoder. No dependencies.
package upe_pkg;

    // How one input byte gets encoded.
    typedef enum logic [1:0] {
        KIND_PASS = 2'd0,   // unreserved, one char
        KIND_ESC  = 2'd1,   // %HH, three chars
        KIND_LAT  = 2'd2    // Latin-1 high byte, %HH%HH, six chars
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_cmd;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] UTF8_LEAD   = 8'hC0;
    localparam logic [7:0] UTF8_CONT   = 8'h80;
    localparam logic [2:0] STEP_LAST_ESC = 3'd2;
    localparam logic [2:0] STEP_LAST_LAT = 3'd5;

    // Upper-case hex digit for a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] w;
        w = {4'h0, n};
        return (n < 4'd10) ? (8'h30 + w) : (8'h37 + w);
    endfunction

endpackage

@@ rtl/upe_ifs.sv @@
`timescale 1ns / 1ps
// upe_ifs: valid/ready channel interfaces for the percent encoder.
// No dependencies.
interface upe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface upe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_last;
    modport source (output valid, output out_char, output run_last, input ready);
    modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

@@ rtl/upe_front.sv @@
`timescale 1ns / 1ps
// upe_front: input handshake and byte classification.
// Depends on upe_pkg and upe_in_if.
module upe_front (
    upe_in_if.sink        i_in,
    input  logic          i_source_is_utf8,
    input  logic          i_q_full,
    output logic          o_push,
    output upe_pkg::t_cmd o_cmd
);
    import upe_pkg::*;

    logic [7:0] c;
    logic       unreserved;

    assign c = i_in.in_byte;

    assign unreserved = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                        (c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h2E ||
                        c == 8'h5F || c == 8'h7E;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_cmd.data = c;
        if (unreserved) begin
            o_cmd.kind = KIND_PASS;
        end else if (c[7] && !i_source_is_utf8) begin
            o_cmd.kind = KIND_LAT;
        end else begin
            o_cmd.kind = KIND_ESC;
        end
    end

endmodule

@@ rtl/upe_queue.sv @@
`timescale 1ns / 1ps
// upe_queue: short command queue between front and back.
// Depends on upe_pkg.
module upe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  upe_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output upe_pkg::t_cmd o_head
);
    import upe_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/upe_back.sv @@
`timescale 1ns / 1ps
// upe_back: character sequencer and output register.
// Depends on upe_pkg and upe_out_if.
module upe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  upe_pkg::t_cmd i_head,
    output logic          o_pop,
    upe_out_if.source     o_out
);
    import upe_pkg::*;

    logic [2:0] r_step, n_step;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;

    logic       load;
    logic       step_last;
    logic [7:0] esc_byte;
    logic [7:0] ch;

    assign load = i_q_valid && (!r_valid || o_out.ready);

    // Byte being escaped: the input itself, or one of its two UTF-8 bytes.
    always_comb begin
        esc_byte = i_head.data;
        if (i_head.kind == KIND_LAT) begin
            if (r_step < 3'd3) begin
                esc_byte = UTF8_LEAD | {6'd0, i_head.data[7:6]};
            end else begin
                esc_byte = UTF8_CONT | {2'd0, i_head.data[5:0]};
            end
        end
    end

    always_comb begin
        ch        = CH_PERCENT;
        step_last = 1'b0;
        unique case (i_head.kind)
            KIND_PASS: begin
                ch        = i_head.data;
                step_last = 1'b1;
            end
            KIND_ESC, KIND_LAT: begin
                case (r_step)
                    3'd1, 3'd4: ch = hex_char(esc_byte[7:4]);
                    3'd2, 3'd5: ch = hex_char(esc_byte[3:0]);
                    default:    ch = CH_PERCENT;
                endcase
                step_last = (i_head.kind == KIND_LAT) ? (r_step == STEP_LAST_LAT)
                                                      : (r_step == STEP_LAST_ESC);
            end
            default: begin
                ch        = i_head.data;
                step_last = 1'b1;
            end
        endcase
    end

    assign o_pop = load && step_last;

    always_comb begin
        n_step = r_step;
        if (load) begin
            n_step = step_last ? 3'd0 : r_step + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= ch;
            r_last <= step_last;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_char = r_char;
    assign o_out.run_last = r_last;

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_LAST_LAT)
        else $error("step counter out of range");
    a_mid_run_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != 3'd0 |-> i_q_valid)
        else $error("run in progress without a queued command");
    a_esc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != 3'd0 && i_head.kind == KIND_ESC) |-> r_step <= STEP_LAST_ESC)
        else $error("escape run longer than three chars");
    a_pop_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid && r_last && r_step == 3'd0)
        else $error("pop without a flagged last char");
`endif

endmodule

@@ rtl/uri_percent_encoder.sv @@
`timescale 1ns / 1ps
// uri_percent_encoder: top level of the URI percent encoder.
// Depends on upe_pkg, upe_ifs, upe_front, upe_queue, upe_back.
//
//  channel   dir  handshake       payload
//  i_in      in   valid/ready     in_byte[7:0]
//  o_out     out  valid/ready     out_char[7:0], run_last
//  cfg       in   i_cfg_we        i_cfg_wdata (source_is_utf8)
//
// One char leaves per cycle while the output is ready; an item takes 1, 3 or 6 chars of the back
//   sequencer (pass-through, %HH, Latin-1 %HH%HH), which sets the rate.
// Items enter one per cycle while the two-entry queue has room.
// An accepted item's first char passes through the queue, then the output register.
// Reset (sync, active low) empties the queue and output stage and clears
//   source_is_utf8 to 0.
// Output stalls hold the output register; input stalls only when the queue fills.
module uri_percent_encoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    upe_in_if.sink    i_in,
    upe_out_if.source o_out,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);
    import upe_pkg::*;

    logic r_source_is_utf8;

    // Front side to queue
    logic q_full;
    logic q_push;
    t_cmd q_in_cmd;

    // Queue to back side
    logic q_valid;
    logic q_pop;
    t_cmd q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_is_utf8 <= 1'b0;
        end else if (i_cfg_we) begin
            r_source_is_utf8 <= i_cfg_wdata;
        end
    end

    // Classify each accepted byte by run shape.
    upe_front u_front (
        .i_in             (i_in),
        .i_source_is_utf8 (r_source_is_utf8),
        .i_q_full         (q_full),
        .o_push           (q_push),
        .o_cmd            (q_in_cmd)
    );

    // Decouples acceptance from char emission.
    upe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Walks the run one char per cycle, while the output is not stalled, into the output register.
    upe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule
